// File: sv/assert_macros.svh
// Assertion macros shared by the engine and divider RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// File: sv/ptab_pkg.sv
package ptab_pkg;

  localparam int MAX_GATES_DEF = 1024;

  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_EVAP   = 3'd1;
  localparam logic [2:0] KIND_CLAMP  = 3'd2;
  localparam logic [2:0] KIND_DEPOSIT = 3'd3;
  localparam logic [2:0] KIND_SELECT = 3'd4;

  localparam logic [2:0] CFG_EVAP_RATE     = 3'd0;
  localparam logic [2:0] CFG_GREEDY_PROB   = 3'd1;
  localparam logic [2:0] CFG_TRAIL_FLOOR   = 3'd2;
  localparam logic [2:0] CFG_TRAIL_CEILING = 3'd3;
  localparam logic [2:0] CFG_GATES_IN_USE  = 3'd4;

  localparam logic [15:0] EVAP_RATE_RST     = 16'd6554;
  localparam logic [15:0] GREEDY_PROB_RST   = 16'd0;
  localparam logic [31:0] TRAIL_FLOOR_RST   = 32'd0;
  localparam logic [31:0] TRAIL_CEILING_RST = 32'hFFFF_FFFF;
  localparam logic [10:0] GATES_IN_USE_RST  = 11'd1024;

  localparam int DIVD_W = 40;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  gate;
    logic        choice;
    logic [31:0] init_value;
    logic [7:0]  weight;
    logic [31:0] score;
    logic [15:0] rand_greedy;
    logic [15:0] rand_pick;
    logic [7:0]  ant;
  } in_word_t;

  typedef struct packed {
    logic [2:0] done_kind;
    logic [7:0] ant_tag;
    logic [9:0] gate_tag;
    logic       chosen;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/pheromone_table_engine.sv
// Channel   Direction  Handshake         Word
// in_       input      in_valid/in_stall  in_word_t, one operation
// out_      output     out_valid/out_stall out_word_t, one result per operation
// cfg_      input      cfg_valid/cfg_ready index and 32-bit data
// Sweeps (init, evaporate, clamp) cover 2*min(gates_in_use, MAX_GATES) entries,
// one table entry read and written per cycle.
// Deposit waits on the 40-step shift-subtract divider, then updates one entry.
// Select does two reads on the one read port, a multiply, a compare.
// Reset is synchronous on rst_n and clears control state only; the table is
// undefined until an init sweep writes it.
// A stalled result holds the engine in its final state until taken.
`include "assert_macros.svh"

module pheromone_table_engine
  import ptab_pkg::*;
#(
  parameter int MAX_GATES = MAX_GATES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DEPTH  = 2 * MAX_GATES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SWEEP = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_RD0   = 8'b0000_1000,
    ST_RD1   = 8'b0001_0000,
    ST_CALC  = 8'b0010_0000,
    ST_CMP   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  in_word_t op_r, op_nxt;
  logic [15:0] evap_r, greedy_r;
  logic [31:0] floor_r, ceil_r;
  logic [10:0] gates_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, len_r, len_nxt;
  logic rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic gate_ok_r, gate_ok_nxt;
  logic [31:0] p0_r, p0_nxt;
  logic [48:0] prod_r, prod_nxt;
  logic greedy_hit_r, greedy_hit_nxt;
  logic chosen_r, chosen_nxt;
  logic out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;

  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr, idx_c, idx0, idx1;
  logic [31:0] mem_wdata, rdata, gmin, p1;
  logic [16:0] factor;
  logic [48:0] evap_prod;
  logic [32:0] psum, dsum;
  logic div_start;
  div_stat_t div_stat;
  logic [DIVD_W-1:0] quotient;

  ptab_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(rdata)
  );

  ptab_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend({in_data.weight, 32'd0}), .divisor(in_data.score),
    .stat(div_stat), .quotient(quotient)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign div_start = in_valid && !in_stall && (in_data.kind == KIND_DEPOSIT);

  assign idx_c = ADDR_W'({21'd0, op_r.gate, op_r.choice});
  assign idx0  = ADDR_W'({21'd0, op_r.gate, 1'b0});
  assign idx1  = ADDR_W'({21'd0, op_r.gate, 1'b1});
  assign gmin  = (32'(gates_r) > 32'(MAX_GATES)) ? 32'(MAX_GATES) : 32'(gates_r);
  assign factor = 17'h1_0000 - {1'b0, evap_r};
  assign evap_prod = 49'(rdata) * 49'(factor);
  assign p1   = gate_ok_r ? rdata : 32'd0;
  assign psum = {1'b0, p0_r} + {1'b0, p1};
  assign dsum = {1'b0, rdata} + {1'b0, quotient[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evap_r   <= EVAP_RATE_RST;
      greedy_r <= GREEDY_PROB_RST;
      floor_r  <= TRAIL_FLOOR_RST;
      ceil_r   <= TRAIL_CEILING_RST;
      gates_r  <= GATES_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EVAP_RATE:     evap_r   <= cfg_data[15:0];
        CFG_GREEDY_PROB:   greedy_r <= cfg_data[15:0];
        CFG_TRAIL_FLOOR:   floor_r  <= cfg_data;
        CFG_TRAIL_CEILING: ceil_r   <= cfg_data;
        CFG_GATES_IN_USE:  gates_r  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    len_nxt = len_r;
    rd_vld_nxt = 1'b0;
    rd_addr_nxt = rd_addr_r;
    gate_ok_nxt = gate_ok_r;
    p0_nxt = p0_r;
    prod_nxt = prod_r;
    greedy_hit_nxt = greedy_hit_r;
    chosen_nxt = chosen_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    mem_we = 1'b0;
    mem_waddr = rd_addr_r;
    mem_wdata = rdata;
    mem_raddr = cnt_r[ADDR_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data;
          cnt_nxt = '0;
          len_nxt = CNT_W'({gmin[30:0], 1'b0});
          chosen_nxt = 1'b0;
          gate_ok_nxt = (32'(in_data.gate) < 32'(MAX_GATES));
          case (in_data.kind)
            KIND_INIT, KIND_EVAP, KIND_CLAMP: state_nxt = ST_SWEEP;
            KIND_DEPOSIT: state_nxt = ST_DIV;
            KIND_SELECT:  state_nxt = ST_RD0;
            default:      state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (cnt_r < len_r) begin
          rd_vld_nxt = 1'b1;
          rd_addr_nxt = cnt_r[ADDR_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ST_DONE;
        end
        if (rd_vld_r) begin
          mem_we = 1'b1;
          case (op_r.kind)
            KIND_INIT: mem_wdata = op_r.init_value;
            KIND_EVAP: mem_wdata = evap_prod[47:16];
            default: begin
              if (rdata < floor_r) begin
                mem_wdata = floor_r;
              end else if (rdata > ceil_r) begin
                mem_wdata = ceil_r;
              end else begin
                mem_wdata = rdata;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = gate_ok_r ? ST_RD0 : ST_DONE;
        end
      end
      ST_RD0: begin
        mem_raddr = (op_r.kind == KIND_DEPOSIT) ? idx_c : idx0;
        state_nxt = (op_r.kind == KIND_DEPOSIT) ? ST_CALC : ST_RD1;
      end
      ST_RD1: begin
        mem_raddr = idx1;
        p0_nxt = gate_ok_r ? rdata : 32'd0;
        greedy_hit_nxt = (greedy_r != 16'd0) && (op_r.rand_greedy < greedy_r);
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (op_r.kind == KIND_DEPOSIT) begin
          mem_we = 1'b1;
          mem_waddr = idx_c;
          mem_wdata = ((quotient[DIVD_W-1:32] != '0) || dsum[32]) ?
                      32'hFFFF_FFFF : dsum[31:0];
          state_nxt = ST_DONE;
        end else begin
          prod_nxt = 49'(op_r.rand_pick) * 49'(psum);
          chosen_nxt = !(p1 < p0_r);
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!greedy_hit_r) begin
          chosen_nxt = !(prod_r < {1'b0, p0_r, 16'd0});
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt.done_kind = op_r.kind;
          out_nxt.ant_tag = op_r.ant;
          out_nxt.gate_tag = op_r.gate;
          out_nxt.chosen = (op_r.kind == KIND_SELECT) ? chosen_r : 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r <= 1'b0;
      cnt_r <= '0;
      len_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r <= rd_vld_nxt;
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
    op_r <= op_nxt;
    rd_addr_r <= rd_addr_nxt;
    gate_ok_r <= gate_ok_nxt;
    p0_r <= p0_nxt;
    prod_r <= prod_nxt;
    greedy_hit_r <= greedy_hit_nxt;
    chosen_r <= chosen_nxt;
    out_r <= out_nxt;
  end

  `ASSERT_IMPLIES(a_we_state, clk, rst_n, mem_we, (state_r == ST_SWEEP) || (state_r == ST_CALC), "Table written outside a write state.")
  `ASSERT_IMPLIES(a_div_state, clk, rst_n, div_stat.done, state_r == ST_DIV, "Divider finished outside the deposit wait.")
  `ASSERT_IMPLIES(a_sweep_cnt, clk, rst_n, state_r == ST_SWEEP, cnt_r <= len_r, "Sweep counter passed its length.")

endmodule

// File: sv/ptab_mem.sv
module ptab_mem #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ptab_div.sv
`include "assert_macros.svh"

module ptab_div
  import ptab_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [31:0]       divisor,
  output div_stat_t         stat,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] dq_r, dq_nxt;
  logic [32:0]       rem_r, rem_nxt;
  logic [31:0]       dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [32:0]       rem_sh;
  logic              qbit;

  always_comb begin
    rem_sh  = {rem_r[31:0], dq_r[DIVD_W-1]};
    qbit    = (rem_sh >= {1'b0, dvs_r});
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DIVD_W-2:0], qbit};
      rem_nxt = qbit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

  `ASSERT_ALWAYS(a_div_cnt, clk, rst_n, cnt_r <= CNT_W'(DIVD_W), "Divider step count overran.")
  `ASSERT_IMPLIES(a_div_done, clk, rst_n, done_r, !busy_r, "Divider done while busy.")

endmodule
